[hw/rtl/assert_macros.svh]
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SRX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SRX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/srx_pkg.sv]
package srx_pkg;

    localparam int SUB_BLOCK_PAIRS_DEF = 1;
    localparam int MAX_ENTRIES_DEF     = 1024;

    localparam int COST_W   = 4;
    localparam int ROUNDS_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_COST_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_ROUNDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_MIX  = 2'd2;

    localparam logic [COST_W-1:0]   COST_RST   = 4'd10;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RST = 5'd8;

    typedef logic [15:0][31:0] state_t;
    typedef logic [3:0][31:0]  quad_t;

    typedef struct packed {
        logic        load;
        logic [3:0]  load_idx;
        logic [31:0] load_data;
        logic        step;
        logic        odd;
        logic        chacha;
    } core_ctl_t;

    // [family: 0 salsa, 1 chacha][half round][quarter][a,b,c,d]
    localparam int QIDX [2][2][4][4] = '{
        '{ '{ '{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11} },
           '{ '{0, 1, 2, 3},  '{5, 6, 7, 4},  '{10, 11, 8, 9}, '{15, 12, 13, 14} } },
        '{ '{ '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15} },
           '{ '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14} } }
    };

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic quad_t salsa_qr(input quad_t q);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        quad_t r;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        b = b ^ rotl(a + d, 7);
        c = c ^ rotl(b + a, 9);
        d = d ^ rotl(c + b, 13);
        a = a ^ rotl(d + c, 18);
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

    function automatic quad_t chacha_qr(input quad_t q);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        quad_t r;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b;
        d = rotl(d ^ a, 16);
        c = c + d;
        b = rotl(b ^ c, 12);
        a = a + b;
        d = rotl(d ^ a, 8);
        c = c + d;
        b = rotl(b ^ c, 7);
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

    function automatic state_t half_round(input state_t w, input int fam, input int st);
        state_t r;
        quad_t q;
        int qi;
        int j;
        r = w;
        for (qi = 0; qi < 4; qi++) begin
            for (j = 0; j < 4; j++) begin
                q[j] = w[QIDX[fam][st][qi][j]];
            end
            q = (fam == 1) ? chacha_qr(q) : salsa_qr(q);
            for (j = 0; j < 4; j++) begin
                r[QIDX[fam][st][qi][j]] = q[j];
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/srx_core.sv]
module srx_core
(
    input  logic              clk,
    input  srx_pkg::core_ctl_t ctl,
    output srx_pkg::state_t   sum
);

    srx_pkg::state_t w_reg;
    srx_pkg::state_t w_next;
    srx_pkg::state_t src_reg;
    srx_pkg::state_t src_next;
    srx_pkg::state_t hr_s0;
    srx_pkg::state_t hr_s1;
    srx_pkg::state_t hr_c0;
    srx_pkg::state_t hr_c1;

    assign hr_s0 = srx_pkg::half_round(w_reg, 0, 0);
    assign hr_s1 = srx_pkg::half_round(w_reg, 0, 1);
    assign hr_c0 = srx_pkg::half_round(w_reg, 1, 0);
    assign hr_c1 = srx_pkg::half_round(w_reg, 1, 1);

    always_comb
    begin
        w_next   = w_reg;
        src_next = src_reg;
        if (ctl.load)
        begin
            w_next[ctl.load_idx]   = ctl.load_data;
            src_next[ctl.load_idx] = ctl.load_data;
        end
        else if (ctl.step)
        begin
            case ({ctl.chacha, ctl.odd})
                2'b00:   w_next = hr_s0;
                2'b01:   w_next = hr_s1;
                2'b10:   w_next = hr_c0;
                default: w_next = hr_c1;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        src_reg <= src_next;
    end

    // feed-forward
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            sum[k] = w_reg[k] + src_reg[k];
        end
    end

endmodule

[hw/rtl/scrypt_romix_core_top.sv]
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// input    | start / busy        | block_word[31:0], block_end
// result   | result_valid strobe | result_word[31:0], result_last
// config   | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[4:0]
//
// Input words are taken one per cycle while idle; block_end starts ROMix and busy
// stays high until the last result. ROMix runs 2n BlockMix passes per chain (two
// chains with double_mix), after a copy of the block with double_mix, and then
// emits BW words. The scratchpad and block RAMs move one word a cycle.
// Async active-low reset clears control and config only.
// Results are strobed for one cycle each, back to back; the receiver cannot stall.
module scrypt_romix_core_top
#(
    parameter int SUB_BLOCK_PAIRS = srx_pkg::SUB_BLOCK_PAIRS_DEF,
    parameter int MAX_ENTRIES     = srx_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [31:0]                     block_word,
    input  logic                            block_end,
    output logic                            result_valid,
    output logic [31:0]                     result_word,
    output logic                            result_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srx_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUBS   = 2 * SUB_BLOCK_PAIRS;
    localparam int BW     = 32 * SUB_BLOCK_PAIRS;
    localparam int SW     = $clog2(SUBS);
    localparam int WW     = SW + 4;
    localparam int CW     = WW + 1;
    localparam int ELW    = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int BDEPTH = 2 * (2 ** WW);
    localparam int SDEPTH = (2 ** ELW) * (2 ** WW);

    localparam logic [SW-1:0] LAST_SUB = SW'(SUBS - 1);
    localparam logic [WW-1:0] LAST_WORD = WW'(BW - 1);
    localparam logic [CW-1:0] BW_C = CW'(BW);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_COPY  = 8'b0000_0010,
        S_PLOAD = 8'b0000_0100,
        S_SREAD = 8'b0000_1000,
        S_ROUND = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_SWR   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } fsm_t;

    fsm_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  load_cnt_reg, load_cnt_next;
    logic           rd_v_reg, rd_v_next;
    logic [WW-1:0]  rd_word_reg, rd_word_next;
    logic [SW-1:0]  sub_reg, sub_next;
    logic [ELW-1:0] pass_reg, pass_next;
    logic [ELW-1:0] j_reg, j_next;
    logic           mix_reg, mix_next;
    logic           ch_reg, ch_next;
    logic           bank_main_reg, bank_main_next;
    logic           bank_sec_reg, bank_sec_next;
    logic [4:0]     rcnt_reg, rcnt_next;
    srx_pkg::state_t prev_reg, prev_next;
    logic [srx_pkg::COST_W-1:0]   cost_reg;
    logic [srx_pkg::ROUNDS_W-1:0] rounds_reg;
    logic           dmix_reg;
    logic [31:0]    res_word_reg, res_word_next;
    logic           res_valid_reg, res_valid_next;
    logic           res_last_reg, res_last_next;

    logic [31:0] main_mem [BDEPTH];
    logic [31:0] sec_mem  [BDEPTH];
    logic [31:0] sp_mem   [SDEPTH];
    logic [31:0] main_q_reg, sec_q_reg, sp_q_reg;

    logic          main_we, main_re, sec_we, sec_re, sp_we, sp_re;
    logic [WW:0]   main_wa, main_ra, sec_wa, sec_ra;
    logic [31:0]   main_wd, sec_wd;
    logic [ELW+WW-1:0] sp_wa, sp_ra;

    logic           accept;
    logic           iss;
    logic [WW-1:0]  iss_word;
    logic           bank_cur;
    logic [SW-1:0]  dsub;
    logic [WW-1:0]  dst_word;
    logic [31:0]    blk_q;
    logic [31:0]    rdata;
    logic [31:0]    emit_val;
    logic [ELW-1:0] nmask;
    logic [srx_pkg::COST_W-1:0] cost_eff;
    logic [4:0]     rtotal;
    logic           blk_phase;
    logic           wr_last;

    srx_pkg::core_ctl_t core_ctl;
    srx_pkg::state_t    core_sum;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = ~busy;
    assign accept    = start & ~busy;

    assign cost_eff = (cost_reg > srx_pkg::COST_W'(ELW)) ? srx_pkg::COST_W'(ELW) : cost_reg;
    assign nmask    = ELW'((1 << cost_eff) - 1);
    assign rtotal   = {rounds_reg[4:1], 1'b0};

    assign blk_phase = (state_reg == S_PLOAD) || (state_reg == S_SREAD);
    assign bank_cur  = ch_reg ? bank_sec_reg : bank_main_reg;

    always_comb
    begin
        unique case (state_reg)
            S_PLOAD: iss_word = {LAST_SUB, cnt_reg[3:0]};
            S_SREAD: iss_word = {sub_reg, cnt_reg[3:0]};
            default: iss_word = cnt_reg[WW-1:0];
        endcase
    end

    assign iss = (blk_phase && (cnt_reg < CW'(16)))
              || (((state_reg == S_COPY) || (state_reg == S_EMIT)) && (cnt_reg < BW_C));

    assign dsub     = sub_reg[0] ? (SW'(SUB_BLOCK_PAIRS) + (sub_reg >> 1)) : (sub_reg >> 1);
    assign dst_word = {dsub, cnt_reg[3:0]};
    assign wr_last  = (cnt_reg[3:0] == 4'd15);

    assign blk_q    = ch_reg ? sec_q_reg : main_q_reg;
    assign rdata    = blk_q ^ (mix_reg ? sp_q_reg : 32'd0);
    assign emit_val = main_q_reg ^ (dmix_reg ? sec_q_reg : 32'd0);

    // memory ports
    always_comb
    begin
        main_re = iss && ((blk_phase && !ch_reg) || (state_reg == S_COPY)
                          || (state_reg == S_EMIT));
        main_ra = {bank_cur, iss_word};
        if (state_reg == S_COPY || state_reg == S_EMIT)
        begin
            main_ra = {bank_main_reg, iss_word};
        end
        sec_re = iss && ((blk_phase && ch_reg) || (state_reg == S_EMIT));
        sec_ra = (state_reg == S_EMIT) ? {bank_sec_reg, iss_word} : {bank_cur, iss_word};
        sp_re  = iss && blk_phase && mix_reg;
        sp_ra  = {j_reg, iss_word};

        main_we = 1'b0;
        main_wa = {bank_main_reg, load_cnt_reg[WW-1:0]};
        main_wd = block_word;
        if (accept && (load_cnt_reg < BW_C))
        begin
            main_we = 1'b1;
        end
        else if (state_reg == S_SWR && !ch_reg)
        begin
            main_we = 1'b1;
            main_wa = {~bank_main_reg, dst_word};
            main_wd = prev_reg[cnt_reg[3:0]];
        end
        else if (state_reg == S_EMIT && rd_v_reg)
        begin
            main_we = 1'b1;
            main_wa = {bank_main_reg, rd_word_reg};
            main_wd = emit_val;
        end

        sec_we = 1'b0;
        sec_wa = {bank_sec_reg, rd_word_reg};
        sec_wd = main_q_reg;
        if (state_reg == S_COPY && rd_v_reg)
        begin
            sec_we = 1'b1;
        end
        else if (state_reg == S_SWR && ch_reg)
        begin
            sec_we = 1'b1;
            sec_wa = {~bank_sec_reg, dst_word};
            sec_wd = prev_reg[cnt_reg[3:0]];
        end

        sp_we = (state_reg == S_SREAD) && rd_v_reg && !mix_reg;
        sp_wa = {pass_reg, rd_word_reg};
    end

    always_ff @(posedge clk)
    begin
        if (main_we)
        begin
            main_mem[main_wa] <= main_wd;
        end
        if (main_re)
        begin
            main_q_reg <= main_mem[main_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sec_we)
        begin
            sec_mem[sec_wa] <= sec_wd;
        end
        if (sec_re)
        begin
            sec_q_reg <= sec_mem[sec_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sp_mem[sp_wa] <= blk_q;
        end
        if (sp_re)
        begin
            sp_q_reg <= sp_mem[sp_ra];
        end
    end

    always_comb
    begin
        core_ctl.load      = (state_reg == S_SREAD) && rd_v_reg;
        core_ctl.load_idx  = rd_word_reg[3:0];
        core_ctl.load_data = rdata ^ prev_reg[rd_word_reg[3:0]];
        core_ctl.step      = (state_reg == S_ROUND);
        core_ctl.odd       = rcnt_reg[0];
        core_ctl.chacha    = ch_reg;
    end

    srx_core u_core
    (
        .clk (clk),
        .ctl (core_ctl),
        .sum (core_sum)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        load_cnt_next  = load_cnt_reg;
        rd_v_next      = iss;
        rd_word_next   = iss_word;
        sub_next       = sub_reg;
        pass_next      = pass_reg;
        j_next         = j_reg;
        mix_next       = mix_reg;
        ch_next        = ch_reg;
        bank_main_next = bank_main_reg;
        bank_sec_next  = bank_sec_reg;
        rcnt_next      = rcnt_reg;
        prev_next      = prev_reg;
        res_word_next  = res_word_reg;
        res_valid_next = 1'b0;
        res_last_next  = 1'b0;

        if (iss)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (load_cnt_reg < BW_C)
                    begin
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                    if (block_end)
                    begin
                        cnt_next  = '0;
                        mix_next  = 1'b0;
                        pass_next = '0;
                        sub_next  = '0;
                        if (dmix_reg)
                        begin
                            state_next = S_COPY;
                        end
                        else
                        begin
                            ch_next    = 1'b0;
                            state_next = S_PLOAD;
                        end
                    end
                end
            end
            S_COPY:
            begin
                if (rd_v_reg && rd_word_reg == LAST_WORD)
                begin
                    state_next = S_PLOAD;
                    cnt_next   = '0;
                    ch_next    = 1'b1;
                end
            end
            S_PLOAD:
            begin
                if (rd_v_reg)
                begin
                    prev_next[rd_word_reg[3:0]] = rdata;
                    if (rd_word_reg[3:0] == 4'd15)
                    begin
                        state_next = S_SREAD;
                        cnt_next   = '0;
                    end
                end
            end
            S_SREAD:
            begin
                if (rd_v_reg && rd_word_reg[3:0] == 4'd15)
                begin
                    rcnt_next  = '0;
                    state_next = (rtotal == 5'd0) ? S_FIN : S_ROUND;
                end
            end
            S_ROUND:
            begin
                rcnt_next = rcnt_reg + 5'd1;
                if (rcnt_reg == rtotal - 5'd1)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                prev_next  = core_sum;
                cnt_next   = '0;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (wr_last)
                begin
                    cnt_next = '0;
                    if (sub_reg == LAST_SUB)
                    begin
                        sub_next = '0;
                        j_next   = prev_reg[0][ELW-1:0] & nmask;
                        if (ch_reg)
                        begin
                            bank_sec_next = ~bank_sec_reg;
                        end
                        else
                        begin
                            bank_main_next = ~bank_main_reg;
                        end
                        if (pass_reg != nmask)
                        begin
                            pass_next  = pass_reg + ELW'(1);
                            state_next = S_PLOAD;
                        end
                        else if (!mix_reg)
                        begin
                            mix_next   = 1'b1;
                            pass_next  = '0;
                            state_next = S_PLOAD;
                        end
                        else if (ch_reg)
                        begin
                            ch_next    = 1'b0;
                            mix_next   = 1'b0;
                            pass_next  = '0;
                            state_next = S_PLOAD;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        sub_next   = sub_reg + SW'(1);
                        state_next = S_SREAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (rd_v_reg)
                begin
                    res_word_next  = emit_val;
                    res_valid_next = 1'b1;
                    if (rd_word_reg == LAST_WORD)
                    begin
                        res_last_next = 1'b1;
                        load_cnt_next = '0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            load_cnt_reg  <= '0;
            rd_v_reg      <= 1'b0;
            sub_reg       <= '0;
            pass_reg      <= '0;
            j_reg         <= '0;
            mix_reg       <= 1'b0;
            ch_reg        <= 1'b0;
            bank_main_reg <= 1'b0;
            bank_sec_reg  <= 1'b0;
            rcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            load_cnt_reg  <= load_cnt_next;
            rd_v_reg      <= rd_v_next;
            sub_reg       <= sub_next;
            pass_reg      <= pass_next;
            j_reg         <= j_next;
            mix_reg       <= mix_next;
            ch_reg        <= ch_next;
            bank_main_reg <= bank_main_next;
            bank_sec_reg  <= bank_sec_next;
            rcnt_reg      <= rcnt_next;
            res_valid_reg <= res_valid_next;
            res_last_reg  <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg  <= rd_word_next;
        prev_reg     <= prev_next;
        res_word_reg <= res_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg   <= srx_pkg::COST_RST;
            rounds_reg <= srx_pkg::ROUNDS_RST;
            dmix_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                srx_pkg::CFG_COST_LOG2:   cost_reg   <= cfg_data[srx_pkg::COST_W-1:0];
                srx_pkg::CFG_CORE_ROUNDS: rounds_reg <= cfg_data[srx_pkg::ROUNDS_W-1:0];
                srx_pkg::CFG_DOUBLE_MIX:  dmix_reg   <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;
    assign result_last  = res_last_reg;

endmodule

[hw/rtl/srx_checker.sv]
`include "assert_macros.svh"

module srx_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           block_end,
    input logic                           result_valid,
    input logic                           result_last,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // result beats of one block come back to back
    `SRX_ASSERT_NXT(a_beats_contig, result_valid && !result_last, result_valid)
    // block end launches the run
    `SRX_ASSERT_NXT(a_end_busy, start && !busy && block_end, busy)
    // the final beat leaves the block idle
    `SRX_ASSERT_IMP(a_last_idle, result_valid && result_last, !busy)
    `SRX_ASSERT_IMP(a_last_valid, result_last, result_valid)
    `SRX_ASSERT_IMP(a_cfg_idle, !busy, cfg_ready)

endmodule

bind scrypt_romix_core_top srx_checker u_srx_checker (.*);

[dv/tb_scrypt_romix_core_top.sv]
module tb_scrypt_romix_core_top;

    localparam int BW = 32;
    localparam int PAD_ENTRIES = 1024;
    localparam int IDLE_LIMIT = 2000000;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } mixed_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [31:0]                    block_word;
    logic                           block_end;
    logic                           result_valid;
    logic [31:0]                    result_word;
    logic                           result_last;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [srx_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [srx_pkg::CFG_DATA_W-1:0] cfg_data;

    scrypt_romix_core_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .block_word   (block_word),
        .block_end    (block_end),
        .result_valid (result_valid),
        .result_word  (result_word),
        .result_last  (result_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [3:0]  cost_sh;
    logic [4:0]  rounds_sh;
    logic        dmix_sh;
    logic [31:0] main_words [BW];
    logic [31:0] copy_words [BW];
    logic [31:0] work_words [BW];
    logic [31:0] mix_words [BW];
    logic [31:0] pad_words [PAD_ENTRIES*BW];
    logic [31:0] core_x [16];
    int          loaded;

    mixed_word_t mixed_q [$];
    int          mismatches;
    int          failures;
    int          burst_left;
    int          words_sent;
    int          blocks_sent;
    int          results_seen;
    int          idle_cycles;
    logic [4:0]  rounds_seen;
    logic [3:0]  costs_seen;

    function automatic logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task salsa_q(input int a, input int b, input int c, input int d);
        core_x[b] = core_x[b] ^ rol(core_x[a] + core_x[d], 7);
        core_x[c] = core_x[c] ^ rol(core_x[b] + core_x[a], 9);
        core_x[d] = core_x[d] ^ rol(core_x[c] + core_x[b], 13);
        core_x[a] = core_x[a] ^ rol(core_x[d] + core_x[c], 18);
    endtask

    task chacha_q(input int a, input int b, input int c, input int d);
        core_x[a] = core_x[a] + core_x[b]; core_x[d] = rol(core_x[d] ^ core_x[a], 16);
        core_x[c] = core_x[c] + core_x[d]; core_x[b] = rol(core_x[b] ^ core_x[c], 12);
        core_x[a] = core_x[a] + core_x[b]; core_x[d] = rol(core_x[d] ^ core_x[a], 8);
        core_x[c] = core_x[c] + core_x[d]; core_x[b] = rol(core_x[b] ^ core_x[c], 7);
    endtask

    task permute_sub(input int src, input int dst, input bit cha);
        int k;
        for (k = 0; k < 16; k++) core_x[k] = work_words[src+k];
        for (k = 0; k < rounds_sh / 2; k++) begin
            if (cha) begin
                chacha_q(0, 4, 8, 12);  chacha_q(1, 5, 9, 13);
                chacha_q(2, 6, 10, 14); chacha_q(3, 7, 11, 15);
                chacha_q(0, 5, 10, 15); chacha_q(1, 6, 11, 12);
                chacha_q(2, 7, 8, 13);  chacha_q(3, 4, 9, 14);
            end
            else begin
                salsa_q(0, 4, 8, 12);   salsa_q(5, 9, 13, 1);
                salsa_q(10, 14, 2, 6);  salsa_q(15, 3, 7, 11);
                salsa_q(0, 1, 2, 3);    salsa_q(5, 6, 7, 4);
                salsa_q(10, 11, 8, 9);  salsa_q(15, 12, 13, 14);
            end
        end
        for (k = 0; k < 16; k++) mix_words[dst+k] = core_x[k] + work_words[src+k];
    endtask

    task chain_mix(input bit cha);
        int k;
        for (k = 0; k < 16; k++) work_words[k] = work_words[k] ^ work_words[16+k];
        permute_sub(0, 0, cha);
        for (k = 0; k < 16; k++) work_words[16+k] = work_words[16+k] ^ mix_words[k];
        permute_sub(16, 16, cha);
        for (k = 0; k < BW; k++) work_words[k] = mix_words[k];
    endtask

    task romix_chain(input int n, input bit cha);
        int i;
        int k;
        int e;
        for (i = 0; i < n; i++) begin
            for (k = 0; k < BW; k++) pad_words[i*BW+k] = work_words[k];
            chain_mix(cha);
        end
        for (i = 0; i < n; i++) begin
            e = work_words[16] & (n - 1);
            for (k = 0; k < BW; k++) work_words[k] = work_words[k] ^ pad_words[e*BW+k];
            chain_mix(cha);
        end
    endtask

    task absorb_word(input logic [31:0] w, input logic e);
        int n;
        int k;
        mixed_word_t m;
        if (loaded < BW) begin
            main_words[loaded] = w;
            loaded++;
        end
        if (e) begin
            n = 1;
            for (k = 0; k < cost_sh && n * 2 <= PAD_ENTRIES; k++) n = n * 2;
            if (dmix_sh) begin
                for (k = 0; k < BW; k++) work_words[k] = main_words[k];
                romix_chain(n, 1'b1);
                for (k = 0; k < BW; k++) copy_words[k] = work_words[k];
            end
            for (k = 0; k < BW; k++) work_words[k] = main_words[k];
            romix_chain(n, 1'b0);
            for (k = 0; k < BW; k++) begin
                main_words[k] = work_words[k] ^ (dmix_sh ? copy_words[k] : 32'h0);
                m.word = main_words[k];
                m.last = (k == BW - 1);
                mixed_q.push_back(m);
            end
            loaded = 0;
            blocks_sent++;
            rounds_seen = rounds_seen | rounds_sh;
            costs_seen = costs_seen | cost_sh;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        mixed_word_t m;
        if (rst_n && result_valid) begin
            results_seen++;
            if (mixed_q.size() == 0) begin
                failures++;
                $display("unexpected result word %h", result_word);
            end
            else begin
                m = mixed_q.pop_front();
                if (m.word !== result_word || m.last !== result_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0b got %h/%0b", m.word, m.last,
                                 result_word, result_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task send_word(input logic [31:0] w, input logic e);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start = 1'b1;
        block_word = w;
        block_end = e;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        absorb_word(w, e);
        words_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task send_block(input int len, input int pattern);
        int i;
        logic [31:0] w;
        for (i = 0; i < len; i++) begin
            case (pattern)
                0: w = $urandom;
                1: w = 32'h0;
                2: w = 32'hffff_ffff;
                default: w = (i % 2) ? 32'hffff_ffff : 32'h0;
            endcase
            send_word(w, i == len - 1);
        end
    endtask

    task wait_drained;
        start = 1'b0;
        while (mixed_q.size() != 0) @(negedge clk);
        while (busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task write_reg(input logic [srx_pkg::CFG_IDX_W-1:0] idx,
                   input logic [srx_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        case (idx)
            srx_pkg::CFG_COST_LOG2:   cost_sh = val[3:0];
            srx_pkg::CFG_CORE_ROUNDS: rounds_sh = val;
            srx_pkg::CFG_DOUBLE_MIX:  dmix_sh = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task set_mode(input logic [4:0] cost, input logic [4:0] rnds, input logic [4:0] dm);
        write_reg(srx_pkg::CFG_COST_LOG2, cost);
        write_reg(srx_pkg::CFG_CORE_ROUNDS, rnds);
        write_reg(srx_pkg::CFG_DOUBLE_MIX, dm);
    endtask

    task test_directed;
        set_mode(5'd1, 5'd8, 5'd0);
        send_block(BW, 3);
        set_mode(5'd0, 5'd0, 5'd0);
        send_block(BW, 2);
        set_mode(5'd2, 5'd31, 5'd1);
        send_block(BW + 5, 0);
        set_mode(5'd3, 5'd1, 5'd0);
        send_block(7, 1);
        set_mode(5'd2, 5'd20, 5'd3);
        send_block(BW, 2);
    endtask

    task test_large_cost;
        set_mode(5'd15, 5'd2, 5'd0);
        send_block(BW, 0);
        set_mode(5'd10, 5'd2, 5'd1);
        send_block(BW, 1);
    endtask

    task test_random;
        int kind;
        while (words_sent < 470) begin
            if ($urandom_range(0, 2) == 0)
                set_mode(5'($urandom_range(0, 4)), 5'($urandom_range(0, 31)),
                         5'($urandom));
            else if ($urandom_range(0, 3) == 0)
                wait_drained();
            kind = $urandom_range(0, 9);
            if (kind < 7)
                send_block(BW, 0);
            else if (kind < 9)
                send_block($urandom_range(1, BW - 1), 0);
            else
                send_block($urandom_range(BW + 1, BW + 8), 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        block_word = 32'h0;
        block_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = srx_pkg::CFG_COST_LOG2;
        cfg_data = '0;
        cost_sh = srx_pkg::COST_RST;
        rounds_sh = srx_pkg::ROUNDS_RST;
        dmix_sh = 1'b0;
        loaded = 0;
        mismatches = 0;
        failures = 0;
        burst_left = 0;
        words_sent = 0;
        blocks_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        rounds_seen = '0;
        costs_seen = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_large_cost();
        test_random();
        wait_drained();
        repeat (50) @(negedge clk);

        $display("%0d words in %0d blocks, %0d result words checked", words_sent,
                 blocks_sent, results_seen);
        $display("costs 0..4, 10, 15, rounds 0..31, single and double mix; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && failures == 0 && mixed_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/srx_pkg.sv
hw/rtl/srx_core.sv
hw/rtl/scrypt_romix_core_top.sv
hw/rtl/srx_checker.sv
dv/tb_scrypt_romix_core_top.sv
